FILE: hw/rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants for the text line rasterizer
// Field widths, command and register codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tlr_pkg;

  // Default sizes of the line and font
  localparam int LINE_DOTS_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 32;
  localparam int MAX_WIDTH_DEF  = 32;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int CODE_W     = 8;
  localparam int FADDR_W    = 15;
  localparam int FBYTE_W    = 8;
  localparam int ROW_W      = 5;
  localparam int DOTS_W     = 64;
  localparam int FWB_W      = 3;
  localparam int FH_W       = 6;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_CHAR    = 3'd1,
    CMD_NEWLINE = 3'd2,
    CMD_END     = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_WIDTH  = 1'b0,
    CFG_FONT_HEIGHT = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_OUT,
    S_CH_SIZE,
    S_CH_BASE,
    S_CH_RD,
    S_CH_LD,
    S_CH_OR,
    S_CH_WR
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tlr_ifaces.sv
// ----------------------------------------------------------------------------
// tlr_ifaces: valid/ready channels of the text line rasterizer
// Command channel in, dot word channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlr_cmd_if;
  import tlr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CODE_W-1:0]  char_code;
  logic [FADDR_W-1:0] font_addr;
  logic [FBYTE_W-1:0] font_byte;

  modport source (output valid, cmd, char_code, font_addr, font_byte, input ready);
  modport sink   (input valid, cmd, char_code, font_addr, font_byte, output ready);
endinterface

interface tlr_dots_if;
  import tlr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row;
  logic              word_index;
  logic [DOTS_W-1:0] dots;
  logic              last;

  modport source (output valid, row, word_index, dots, last, input ready);
  modport sink   (input valid, row, word_index, dots, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tlr_line_store.sv
// ----------------------------------------------------------------------------
// tlr_line_store: line buffer, one row of dots per entry
// Single write port, one registered read port, per-row valid bits so that
// a whole-line clear only drops the valid bits. A row not valid reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_line_store #(
  parameter int LINE_DOTS  = tlr_pkg::LINE_DOTS_DEF,
  parameter int MAX_HEIGHT = tlr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     rd_addr,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     wr_addr,
  input  logic [((LINE_DOTS+7)/8)*8-1:0]    wr_data,
  input  logic                              clr_all,
  output logic [((LINE_DOTS+7)/8)*8-1:0]    rd_data
);
  import tlr_pkg::*;

  localparam int ROW_BITS = ((LINE_DOTS + 7) / 8) * 8;

  logic [ROW_BITS-1:0]   mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic [ROW_BITS-1:0]   rd_q;
  logic                  rd_valid_q;

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Row valid bits: a clear drops them all, a write sets one
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_all) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid_q <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/tlr_ctrl.sv
// ----------------------------------------------------------------------------
// tlr_ctrl: sequencer, glyph memory and byte merge unit
// Walks glyph rows into the line buffer one byte per cycle and walks the
// buffer out as 64-dot words through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlr_ctrl #(
  parameter int LINE_DOTS  = tlr_pkg::LINE_DOTS_DEF,
  parameter int MAX_HEIGHT = tlr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = tlr_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]    cfg_data,
  tlr_cmd_if.sink                           chars,
  tlr_dots_if.source                        rows,
  output logic [$clog2(MAX_HEIGHT)-1:0]     lb_rd_addr,
  output logic                              lb_wr_en,
  output logic [$clog2(MAX_HEIGHT)-1:0]     lb_wr_addr,
  output logic [((LINE_DOTS+7)/8)*8-1:0]    lb_wr_data,
  output logic                              lb_clr,
  input  logic [((LINE_DOTS+7)/8)*8-1:0]    lb_rd_data
);
  import tlr_pkg::*;

  localparam int LINE_BYTES  = (LINE_DOTS + 7) / 8;
  localparam int ROW_BITS    = LINE_BYTES * 8;
  localparam int ROW_WORDS   = (LINE_DOTS + 63) / 64;
  localparam int EXT_BITS    = ROW_WORDS * DOTS_W;
  localparam int PW          = $clog2(MAX_HEIGHT);
  localparam int BPW         = $clog2(LINE_BYTES);
  localparam int MAX_WB      = MAX_WIDTH / 8;
  localparam int GLYPH_DEPTH = 2 ** FADDR_W;
  localparam logic [PW-1:0] LAST_P    = PW'(MAX_HEIGHT - 1);
  localparam logic          LAST_WORD = 1'(ROW_WORDS - 1);

  state_t state, state_next;

  // Configuration
  logic [FWB_W-1:0] font_wb;
  logic [FH_W-1:0]  font_h;

  // Control and working registers
  logic [COL_W-1:0]   column;
  logic               ret_char;
  logic [CODE_W-1:0]  code;
  logic [PW-1:0]      p;
  logic [ROW_W-1:0]   r;
  logic               w;
  logic [BPW-1:0]     bp;
  logic [FWB_W-1:0]   rem;
  logic [8:0]         size;
  logic [FADDR_W-1:0] gaddr;
  logic [ROW_BITS-1:0] row_q;

  // Glyph memory
  logic [FBYTE_W-1:0] glyph_mem [GLYPH_DEPTH];
  logic [FBYTE_W-1:0] glyph_q;

  // Output register
  logic              o_valid;
  logic [ROW_W-1:0]  o_row;
  logic              o_word;
  logic [DOTS_W-1:0] o_dots;
  logic              o_last;

  // Combinational helpers
  cmd_t              in_cmd;
  logic              accept;
  logic              glyph_we;
  logic              wb_ok;
  logic              h_ok;
  logic              fits;
  logic              out_free;
  logic              word_last;
  logic              row_last;
  logic              fl_load;
  logic              fl_done;
  logic [FH_W:0]     p_start_w;
  logic [PW-1:0]     p_start;
  logic [16:0]       base_full;
  logic [EXT_BITS-1:0] row_ext;
  logic [DOTS_W-1:0] word_bits;

  assign in_cmd    = cmd_t'(chars.cmd);
  assign chars.ready = (state == S_IDLE);
  assign accept    = chars.valid && chars.ready;
  assign glyph_we  = accept && (in_cmd == CMD_LOAD);

  assign wb_ok     = (font_wb != '0) && (font_wb <= FWB_W'(MAX_WB));
  assign h_ok      = (font_h != '0) && ({1'b0, font_h} <= 7'(MAX_HEIGHT));
  assign fits      = ({1'b0, column} + {3'b000, font_wb, 3'b000}) <= 9'(LINE_DOTS);
  assign out_free  = !o_valid || rows.ready;
  assign word_last = (w == LAST_WORD);
  assign row_last  = (p == LAST_P);

  assign p_start_w = 7'(MAX_HEIGHT) - {1'b0, font_h};
  assign p_start   = p_start_w[PW-1:0];
  assign base_full = {9'b0, code} * {8'b0, size};

  // Word slice of the row being flushed, byte 0 in the top bits
  always_comb begin
    row_ext = EXT_BITS'(lb_rd_data);
    for (int b = 0; b < 8; b++) begin
      word_bits[DOTS_W-1-8*b -: 8] = row_ext[int'(w)*DOTS_W + 8*b +: 8];
    end
  end

  // Line buffer port
  assign lb_rd_addr = p;
  assign lb_wr_addr = p;
  assign lb_wr_data = row_q;
  assign lb_wr_en   = (state == S_CH_WR);
  assign lb_clr     = fl_done || (accept && (in_cmd == CMD_CLEAR));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    fl_load    = 1'b0;
    fl_done    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (chars.valid) begin
          unique case (in_cmd)
            CMD_CHAR: begin
              if (wb_ok && h_ok) begin
                state_next = fits ? S_CH_SIZE : S_FL_RD;
              end
            end
            CMD_NEWLINE: begin
              if (h_ok) begin
                state_next = S_FL_RD;
              end
            end
            CMD_END: begin
              if (h_ok && (column != '0)) begin
                state_next = S_FL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_FL_RD: state_next = S_FL_OUT;
      S_FL_OUT: begin
        if (out_free) begin
          fl_load = 1'b1;
          if (word_last) begin
            if (row_last) begin
              fl_done    = 1'b1;
              state_next = ret_char ? S_CH_SIZE : S_IDLE;
            end else begin
              state_next = S_FL_RD;
            end
          end
        end
      end
      S_CH_SIZE: state_next = S_CH_BASE;
      S_CH_BASE: state_next = S_CH_RD;
      S_CH_RD:   state_next = S_CH_LD;
      S_CH_LD:   state_next = S_CH_OR;
      S_CH_OR: begin
        if (rem == '0) begin
          state_next = S_CH_WR;
        end
      end
      S_CH_WR: state_next = row_last ? S_IDLE : S_CH_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_wb <= FWB_W'(1);
      font_h  <= FH_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FONT_WIDTH:  font_wb <= cfg_data[FWB_W-1:0];
        CFG_FONT_HEIGHT: font_h  <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Column and request flags
  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      ret_char <= 1'b0;
    end else begin
      if (accept) begin
        ret_char <= (in_cmd == CMD_CHAR);
      end
      if (accept && (in_cmd == CMD_CLEAR)) begin
        column <= '0;
      end else if (fl_done) begin
        column <= '0;
      end else if ((state == S_CH_WR) && row_last) begin
        column <= column + {2'b00, font_wb, 3'b000};
      end
    end
  end

  // Counters and byte merge unit
  always_ff @(posedge clk) begin
    if (accept) begin
      code <= chars.char_code;
      p    <= p_start;
      r    <= '0;
      w    <= 1'b0;
    end
    unique case (state)
      S_FL_OUT: begin
        if (fl_load) begin
          if (word_last) begin
            w <= 1'b0;
            if (!row_last) begin
              p <= p + PW'(1);
              r <= r + ROW_W'(1);
            end
          end else begin
            w <= w + 1'b1;
          end
        end
      end
      S_CH_SIZE: begin
        size <= {6'b0, font_wb} * {3'b0, font_h};
        p    <= p_start;
      end
      S_CH_BASE: gaddr <= base_full[FADDR_W-1:0];
      S_CH_RD: begin
        bp  <= column[BPW+2:3];
        rem <= font_wb - FWB_W'(1);
      end
      S_CH_LD: begin
        row_q <= lb_rd_data;
        gaddr <= gaddr + FADDR_W'(1);
      end
      S_CH_OR: begin
        row_q[{bp, 3'b000} +: 8] <= row_q[{bp, 3'b000} +: 8] | glyph_q;
        if (rem != '0) begin
          rem   <= rem - FWB_W'(1);
          bp    <= bp + BPW'(1);
          gaddr <= gaddr + FADDR_W'(1);
        end
      end
      S_CH_WR: begin
        if (!row_last) begin
          p <= p + PW'(1);
        end
      end
      default: ;
    endcase
  end

  // Glyph memory, registered read
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[chars.font_addr] <= chars.font_byte;
    end
    glyph_q <= glyph_mem[gaddr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fl_load) begin
      o_valid <= 1'b1;
    end else if (rows.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_load) begin
      o_row  <= r;
      o_word <= w;
      o_dots <= word_bits;
      o_last <= word_last && row_last;
    end
  end

  assign rows.valid      = o_valid;
  assign rows.row        = o_row;
  assign rows.word_index = o_word;
  assign rows.dots       = o_dots;
  assign rows.last       = o_last;

  // Checks
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column} <= 9'(LINE_DOTS))
    else $error("dot column past line end");

  a_flush_clears_column: assert property (@(posedge clk) disable iff (rst)
    fl_done |=> (column == '0))
    else $error("column not cleared after flush");

  a_byte_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_CH_OR) |-> (int'(bp) < LINE_BYTES))
    else $error("glyph byte merged outside the line");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (fl_load && word_last && row_last) |=> (rows.valid && rows.last))
    else $error("final word of line not marked");

  a_glyph_step: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CH_OR) && (rem != '0)) |=> (gaddr == $past(gaddr) + FADDR_W'(1)))
    else $error("glyph address did not advance");

endmodule

`default_nettype wire

FILE: hw/rtl/text_line_rasterizer.sv
// ----------------------------------------------------------------------------
// text_line_rasterizer: character stream to dot rows for a thermal head
// Glyphs are ORed into a bottom-aligned line buffer and flushed as 64-dot
// words, one row after the other, with a mark on the final word.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  chars    | in  | cmd, char_code, font_addr, font_byte     | valid/ready
//  rows     | out | row, word_index, dots, last              | valid/ready
//  cfg      | in  | cfg_index, cfg_data                      | cfg_we only
//
//  Load, clear and ignored requests are handled in the idle state alone.
//  Character: size, base, then per glyph row read, load, merge and write;
//  the merge unit takes one glyph byte per cycle; plus a flush if the line
//  is full. Flush: per row a read, then one word per cycle unless stalled.
//  Reset: synchronous; the line buffer reads as zero at once (row valid bits).
//  A stalled output holds the flush in place; no request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_rasterizer #(
  parameter int LINE_DOTS  = tlr_pkg::LINE_DOTS_DEF,
  parameter int MAX_HEIGHT = tlr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = tlr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlr_pkg::CFG_DATA_W-1:0] cfg_data,
  tlr_cmd_if.sink                        chars,
  tlr_dots_if.source                     rows
);
  import tlr_pkg::*;

  localparam int ROW_BITS = ((LINE_DOTS + 7) / 8) * 8;
  localparam int PW       = $clog2(MAX_HEIGHT);

  logic [PW-1:0]       lb_rd_addr;
  logic                lb_wr_en;
  logic [PW-1:0]       lb_wr_addr;
  logic [ROW_BITS-1:0] lb_wr_data;
  logic                lb_clr;
  logic [ROW_BITS-1:0] lb_rd_data;

  // Sequencer with glyph memory and output register
  tlr_ctrl #(
    .LINE_DOTS  (LINE_DOTS),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chars      (chars),
    .rows       (rows),
    .lb_rd_addr (lb_rd_addr),
    .lb_wr_en   (lb_wr_en),
    .lb_wr_addr (lb_wr_addr),
    .lb_wr_data (lb_wr_data),
    .lb_clr     (lb_clr),
    .lb_rd_data (lb_rd_data)
  );

  // Line buffer
  tlr_line_store #(
    .LINE_DOTS  (LINE_DOTS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (lb_rd_addr),
    .wr_en   (lb_wr_en),
    .wr_addr (lb_wr_addr),
    .wr_data (lb_wr_data),
    .clr_all (lb_clr),
    .rd_data (lb_rd_data)
  );

endmodule

`default_nettype wire
